@@ src/lpht_pkg.sv @@
// lpht_pkg: types and constants for the linear probe hash table.
// No dependencies.
`default_nettype none
package lpht_pkg;
    localparam logic [31:0] FIB_MULT = 32'd2654435769;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0, CMD_ADD = 3'd1, CMD_ADD_IF_ABSENT = 3'd2,
        CMD_SCAN_RESTART = 3'd3, CMD_SCAN_NEXT = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FOUND = 3'd0, ST_ABSENT = 3'd1, ST_ADDED = 3'd2, ST_SCAN_ITEM = 3'd3,
        ST_SCAN_DONE = 3'd4, ST_FULL = 3'd5, ST_ZERO_KEY = 3'd6, ST_RESTARTED = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HOME, S_PROBE_RD, S_PROBE_CHK, S_GROW_COPY,
        S_GROW_CLR, S_GROW_RD, S_GROW_HASH, S_GROW_HOME, S_GROW_PRD, S_GROW_PCHK,
        S_SCAN_RD, S_SCAN_CHK, S_OUT
    } state_t;
endpackage
`default_nettype wire

@@ src/lpht_hash.sv @@
// lpht_hash: registered Fibonacci hash and home slot of a key.
// Depends on lpht_pkg.
`default_nettype none
module lpht_hash #(
    parameter int KEY_BITS = 32,
    parameter int LOG2_MAX_SLOTS = 10
) (
    input  wire logic                      clk,
    input  wire logic [KEY_BITS-1:0]       key,
    input  wire logic [4:0]                size_log2,
    output logic      [LOG2_MAX_SLOTS-1:0] home
);
    import lpht_pkg::*;
    localparam int KW = (KEY_BITS > 35) ? 35 : KEY_BITS;
    logic [31:0] shifted;
    logic [31:0] h_reg;
    logic [63:0] prod;
    logic [31:0] top;

    always_comb
    begin
        shifted = '0;
        shifted[KW-4:0] = key[KW-1:3];
    end
    assign prod = shifted * FIB_MULT;

    always_ff @(posedge clk)
    begin
        h_reg <= prod[31:0];
    end

    always_comb
    begin
        top = (size_log2 == 5'd0) ? 32'd0 : (h_reg >> (6'd32 - {1'b0, size_log2}));
        home = top[LOG2_MAX_SLOTS-1:0];
    end
endmodule
`default_nettype wire

@@ src/lpht_ram.sv @@
// lpht_ram: synchronous one-read one-write memory with a registered read port.
// No dependencies.
`default_nettype none
module lpht_ram #(
    parameter int W = 33,
    parameter int AW = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);
    logic [W-1:0] mem [2**AW];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ src/linear_probe_hash_table_top.sv @@
// linear_probe_hash_table_top: open-addressed key set with linear probing.
// Depends on lpht_pkg, lpht_hash, lpht_ram.
// Lookup/add: hash, home slot, then read and check per probed slot; scan next reads slots
// up to an item or the end; others go to output. Growth: buffer, clear, then re-add keys.
// One request at a time; the next is taken while a response waits.
// Reset or config write: clearing pass over all 2^LOG2_MAX_SLOTS slots; config taken anytime.
`default_nettype none
module linear_probe_hash_table_top #(
    parameter int LOG2_MAX_SLOTS = 10,
    parameter int KEY_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,      // [3:0] initial_size_log2
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,       // [2:0] command, [34:3] key
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata        // status, key_out, entries_used, size_log2_out
);
    import lpht_pkg::*;
    localparam int AW = LOG2_MAX_SLOTS;
    localparam int CW = LOG2_MAX_SLOTS + 1;
    localparam int DW = KEY_BITS + 1;

    state_t state_reg, state_next;
    logic [4:0] size_reg, size_next;
    logic [CW-1:0] count_reg, count_next, scan_reg, scan_next, j_reg, j_next, n_reg, n_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next, gkey_reg, gkey_next, kout_reg, kout_next;
    logic [2:0] st_reg, st_next;
    logic out_v_reg, out_v_next;
    logic [2:0] ostat_reg, ostat_next;
    logic [31:0] okey_reg, okey_next;
    logic [10:0] ocnt_reg, ocnt_next;
    logic [3:0] osz_reg, osz_next;

    logic s_we, b_we;
    logic [AW-1:0] s_wa, s_ra, b_wa, b_ra;
    logic [DW-1:0] s_wd, s_rd, b_wd, b_rd;
    logic [KEY_BITS-1:0] hkey;
    logic [AW-1:0] home, mask;
    logic [CW-1:0] slots;
    logic [CW+1:0] thresh;
    logic [31:0] key_in32;

    assign cfg_ready = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata = {6'b0, osz_reg, ocnt_reg, okey_reg, ostat_reg};

    assign slots = CW'(1) << size_reg;
    assign mask = slots[AW-1:0] - AW'(1);
    assign thresh = (CW+2)'((3 * {2'b0, slots}) >> 2);
    assign key_in32 = s_tdata[34:3];
    assign hkey = (state_reg == S_GROW_HASH) ? b_rd[KEY_BITS-1:0] : key_reg;

    lpht_hash #(.KEY_BITS(KEY_BITS), .LOG2_MAX_SLOTS(LOG2_MAX_SLOTS)) u_hash (
        .clk(clk), .key(hkey), .size_log2(size_reg), .home(home));
    lpht_ram #(.W(DW), .AW(AW)) u_slots (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
    lpht_ram #(.W(DW), .AW(AW)) u_buf (
        .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            size_reg <= 5'd4;
            count_reg <= '0;
            scan_reg <= '0;
            j_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            state_reg <= S_CLEAR;
            size_reg <= ({1'b0, cfg_data[3:0]} > 5'(LOG2_MAX_SLOTS)) ?
                        5'(LOG2_MAX_SLOTS) : {1'b0, cfg_data[3:0]};
            count_reg <= '0;
            scan_reg <= '0;
            j_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg <= size_next;
            count_reg <= count_next;
            scan_reg <= scan_next;
            j_reg <= j_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        idx_reg <= idx_next;
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        gkey_reg <= gkey_next;
        kout_reg <= kout_next;
        st_reg <= st_next;
        ostat_reg <= ostat_next;
        okey_reg <= okey_next;
        ocnt_reg <= ocnt_next;
        osz_reg <= osz_next;
    end

    always_comb
    begin
        state_next = state_reg;
        size_next = size_reg;
        count_next = count_reg;
        scan_next = scan_reg;
        j_next = j_reg;
        n_next = n_reg;
        idx_next = idx_reg;
        cmd_next = cmd_reg;
        key_next = key_reg;
        gkey_next = gkey_reg;
        kout_next = kout_reg;
        st_next = st_reg;
        out_v_next = out_v_reg;
        ostat_next = ostat_reg;
        okey_next = okey_reg;
        ocnt_next = ocnt_reg;
        osz_next = osz_reg;
        s_we = 1'b0;
        s_wa = idx_reg;
        s_wd = {1'b1, key_reg};
        s_ra = idx_reg;
        b_we = 1'b0;
        b_wa = j_reg[AW-1:0];
        b_wd = s_rd;
        b_ra = j_reg[AW-1:0];
        if (out_v_reg && m_tready)
            out_v_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                s_we = 1'b1;
                s_wa = j_reg[AW-1:0];
                s_wd = '0;
                j_next = j_reg + CW'(1);
                if (j_reg[AW-1:0] == {AW{1'b1}})
                begin
                    j_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd_next = s_tdata[2:0];
                    key_next = KEY_BITS'(key_in32);
                    kout_next = '0;
                    n_next = '0;
                    if (s_tdata[2:0] <= CMD_ADD_IF_ABSENT && key_next == '0)
                    begin
                        st_next = ST_ZERO_KEY;
                        state_next = S_OUT;
                    end
                    else if (s_tdata[2:0] <= CMD_ADD_IF_ABSENT)
                        state_next = S_HASH;
                    else if (s_tdata[2:0] == CMD_SCAN_RESTART)
                    begin
                        scan_next = '0;
                        st_next = ST_RESTARTED;
                        state_next = S_OUT;
                    end
                    else if (s_tdata[2:0] == CMD_SCAN_NEXT)
                    begin
                        st_next = ST_SCAN_DONE;
                        state_next = (scan_reg < slots) ? S_SCAN_RD : S_OUT;
                    end
                    else
                    begin
                        st_next = ST_ABSENT;
                        state_next = S_OUT;
                    end
                end
            end
            S_HASH:
                state_next = S_HOME;
            S_HOME:
            begin
                idx_next = home & mask;
                state_next = S_PROBE_RD;
            end
            S_PROBE_RD:
                state_next = S_PROBE_CHK;
            S_PROBE_CHK:
            begin
                if (cmd_reg != CMD_ADD && s_rd[DW-1] && s_rd[KEY_BITS-1:0] == key_reg)
                begin
                    st_next = ST_FOUND;
                    kout_next = s_rd[KEY_BITS-1:0];
                    state_next = S_OUT;
                end
                else if (!s_rd[DW-1] || n_reg + CW'(1) >= slots)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        st_next = ST_ABSENT;
                        state_next = S_OUT;
                    end
                    else if ({2'b0, count_reg} + (CW+2)'(1) > thresh)
                    begin
                        if (size_reg >= 5'(LOG2_MAX_SLOTS))
                        begin
                            st_next = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            j_next = '0;
                            state_next = S_GROW_COPY;
                        end
                    end
                    else if (s_rd[DW-1])
                    begin
                        st_next = ST_ADDED;
                        count_next = count_reg + CW'(1);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        s_we = 1'b1;
                        st_next = ST_ADDED;
                        count_next = count_reg + CW'(1);
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    idx_next = (idx_reg + AW'(1)) & mask;
                    n_next = n_reg + CW'(1);
                    state_next = S_PROBE_RD;
                end
            end
            S_GROW_COPY:
            begin
                s_ra = j_reg[AW-1:0];
                if (j_reg != '0)
                begin
                    b_we = 1'b1;
                    b_wa = AW'(j_reg - CW'(1));
                end
                j_next = j_reg + CW'(1);
                if (j_reg == slots)
                begin
                    j_next = '0;
                    state_next = S_GROW_CLR;
                end
            end
            S_GROW_CLR:
            begin
                s_we = 1'b1;
                s_wa = j_reg[AW-1:0];
                s_wd = '0;
                j_next = j_reg + CW'(1);
                if (j_reg + CW'(1) == slots)
                begin
                    j_next = '0;
                    size_next = size_reg + 5'd1;
                    state_next = S_GROW_RD;
                end
            end
            S_GROW_RD:
            begin
                if (j_reg == (slots >> 1))
                begin
                    n_next = '0;
                    state_next = S_HASH;
                    cmd_next = CMD_ADD;
                end
                else
                    state_next = S_GROW_HASH;
            end
            S_GROW_HASH:
            begin
                gkey_next = b_rd[KEY_BITS-1:0];
                if (!b_rd[DW-1])
                begin
                    j_next = j_reg + CW'(1);
                    state_next = S_GROW_RD;
                end
                else
                    state_next = S_GROW_HOME;
            end
            S_GROW_HOME:
            begin
                idx_next = home & mask;
                state_next = S_GROW_PRD;
            end
            S_GROW_PRD:
                state_next = S_GROW_PCHK;
            S_GROW_PCHK:
            begin
                if (!s_rd[DW-1])
                begin
                    s_we = 1'b1;
                    s_wd = {1'b1, gkey_reg};
                    j_next = j_reg + CW'(1);
                    state_next = S_GROW_RD;
                end
                else
                begin
                    idx_next = (idx_reg + AW'(1)) & mask;
                    state_next = S_GROW_PRD;
                end
            end
            S_SCAN_RD:
            begin
                s_ra = scan_reg[AW-1:0];
                scan_next = scan_reg + CW'(1);
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (s_rd[DW-1])
                begin
                    st_next = ST_SCAN_ITEM;
                    kout_next = s_rd[KEY_BITS-1:0];
                    state_next = S_OUT;
                end
                else if (scan_reg < slots)
                    state_next = S_SCAN_RD;
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_v_reg)
                begin
                    out_v_next = 1'b1;
                    ostat_next = st_reg;
                    okey_next = 32'(kout_reg);
                    ocnt_next = 11'(count_reg);
                    osz_next = size_reg[3:0];
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
